>>> rtl/aomc_pkg.sv
// Shared types, constants and helper functions of the Asian option Monte Carlo pricer.
`default_nettype none
package aomc_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int X_W        = 30;
	localparam int PRICE_W    = 32;
	localparam int PSUM_W     = 42;
	localparam int ACC_W      = 64;
	localparam int DAYS_W     = 11;
	localparam int PATHS_W    = 21;
	localparam int P_W        = 26;
	localparam int DIV_N      = 64;
	localparam int DIV_D      = 42;
	localparam int FIFO_DEPTH = 4;

	localparam logic [DAYS_W-1:0]  MAX_DAYS  = 11'd1024;
	localparam logic [PATHS_W-1:0] MAX_PATHS = 21'd1048576;
	localparam logic [24:0]        ONE_Q24   = 25'd16777216;
	localparam logic signed [25:0] LOG2E_Q24 = 26'sd24204406;
	localparam logic [23:0]        LN2_Q24   = 24'd11629080;

	typedef enum logic [2:0] {
		REG_START_PRICE = 3'd0,
		REG_STRIKE      = 3'd1,
		REG_DRIFT       = 3'd2,
		REG_DIFFUSION   = 3'd3,
		REG_DISCOUNT    = 3'd4,
		REG_DAYS        = 3'd5,
		REG_PATHS       = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0]        start_price;
		logic [31:0]        strike_level;
		logic signed [23:0] drift;
		logic [23:0]        diffusion;
		logic [24:0]        discount;
		logic [DAYS_W-1:0]  days;
		logic [PATHS_W-1:0] paths;
	} cfg_t;

	// ceil(2^29 / k): floor(q*m/2^29) equals floor(q/k) for q below 2^26
	function automatic logic [29:0] recip_q29(input logic [2:0] k);
		logic [29:0] m;
		unique case (k)
			3'd2:    m = 30'd268435456;
			3'd3:    m = 30'd178956971;
			3'd4:    m = 30'd134217728;
			3'd5:    m = 30'd107374183;
			3'd6:    m = 30'd89478486;
			3'd7:    m = 30'd76695845;
			default: m = 30'd536870912;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

>>> rtl/aomc_front.sv
// Front end: accepts normal samples and forms the log-price exponent.
`default_nettype none
module aomc_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  aomc_pkg::cfg_t                   cfg,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [aomc_pkg::SAMPLE_W-1:0] in_sample,
	output logic                             push,
	output logic signed [aomc_pkg::X_W-1:0]  push_x,
	input  logic                             full
);
	import aomc_pkg::*;

	logic               valid_s1;
	logic signed [40:0] prod_s1;
	logic               neg;
	logic [40:0]        mag;
	logic [28:0]        rnd;
	logic signed [X_W-1:0] diff;

	assign in_ready = !valid_s1 || !full;
	assign push     = valid_s1 && !full;

	always_comb begin
		neg    = prod_s1[40];
		mag    = neg ? 41'(-prod_s1) : 41'(prod_s1);
		rnd    = 29'((mag + 41'd2048) >> 12);
		diff   = neg ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
		push_x = X_W'(cfg.drift) + diff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			prod_s1 <= $signed({1'b0, cfg.diffusion}) * in_sample;
		end
	end

endmodule
`default_nettype wire

>>> rtl/aomc_fifo.sv
// Short queue of exponents between the front end and the back end.
`default_nettype none
module aomc_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic signed [aomc_pkg::X_W-1:0] push_data,
	output logic                            full,
	input  logic                            pop,
	output logic signed [aomc_pkg::X_W-1:0] pop_data,
	output logic                            empty
);
	import aomc_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	logic signed [X_W-1:0] mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]      wr_q;
	logic [PTR_W-1:0]      rd_q;
	logic [PTR_W:0]        cnt_q;

	assign full     = cnt_q == (PTR_W+1)'(FIFO_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

>>> rtl/aomc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module aomc_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [aomc_pkg::DIV_N-1:0]   dividend,
	input  logic [aomc_pkg::DIV_D-1:0]   divisor,
	output logic                         done,
	output logic [aomc_pkg::DIV_N-1:0]   quotient
);
	import aomc_pkg::*;

	localparam int CNT_W = $clog2(DIV_N);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_D-1:0] rem_q;
	logic [DIV_D-1:0] dsr_q;
	logic [DIV_N-1:0] quo_q;
	logic [DIV_D:0]   trial;
	logic             ge;

	assign done     = done_q;
	assign quotient = quo_q;
	assign trial    = {rem_q, quo_q[DIV_N-1]};
	assign ge       = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_D'(trial - {1'b0, dsr_q}) : DIV_D'(trial);
			quo_q <= {quo_q[DIV_N-2:0], ge};
		end
	end

endmodule
`default_nettype wire

>>> rtl/aomc_back.sv
// Back end: price recurrence, path averaging, payoff accumulation and run statistics.
`default_nettype none
module aomc_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  aomc_pkg::cfg_t                  cfg,
	output logic                            pop,
	input  logic signed [aomc_pkg::X_W-1:0] pop_data,
	input  logic                            empty,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [63:0]                     out_data
);
	import aomc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_YMUL, S_FRAC, S_TMUL, S_HMUL, S_HDIV, S_PMUL, S_PRND, S_PACC,
		S_AVG, S_AVGW, S_PAY, S_DMUL, S_DRND, S_SQMUL, S_SQACC,
		S_MEAN, S_MEANW, S_MMUL, S_MSQ, S_MSMUL, S_DEV, S_VAR, S_VARW,
		S_EXP, S_ROOT, S_OUT
	} state_t;

	state_t state_q;

	logic signed [X_W-1:0] x_q;
	logic signed [55:0]    ymul_q;
	logic signed [6:0]     n_q;
	logic [23:0]           f_q;
	logic [23:0]           t_q;
	logic [P_W-1:0]        p_q;
	logic [P_W-1:0]        hm_q;
	logic [2:0]            k_q;
	logic [41:0]           plo_q;
	logic [41:0]           phi_q;
	logic [PRICE_W-1:0]    price_q;
	logic [PSUM_W-1:0]     psum_q;
	logic [DAYS_W-1:0]     day_q;
	logic [PATHS_W-1:0]    path_q;
	logic [42:0]           avg_q;
	logic [42:0]           payoff_q;
	logic [46:0]           dlo_q;
	logic [45:0]           dhi_q;
	logic [39:0]           d_q;
	logic [39:0]           hh_q;
	logic [39:0]           hl_q;
	logic [39:0]           ll_q;
	logic [ACC_W-1:0]      psum_acc_q;
	logic [ACC_W-1:0]      sq_acc_q;
	logic [ACC_W-1:0]      m_q;
	logic [41:0]           pp_q;
	logic [63:0]           mb_q;
	logic [31:0]           mab_q;
	logic [39:0]           mm_q;
	logic [40:0]           mslo_q;
	logic [40:0]           mshi_q;
	logic [ACC_W-1:0]      dev_q;
	logic [ACC_W-1:0]      v_q;
	logic [3:0]            eh_q;
	logic [63:0]           rv_q;
	logic [63:0]           rr_q;
	logic [63:0]           bit_q;
	logic [4:0]            it_q;
	logic                  out_valid_q;
	logic [63:0]           out_data_q;

	logic                  div_start;
	logic [DIV_N-1:0]      div_dividend;
	logic [DIV_D-1:0]      div_divisor;
	logic                  div_done;
	logic [DIV_N-1:0]      div_quotient;

	logic                  yneg;
	logic [55:0]           ymag;
	logic [31:0]           yr;
	logic signed [31:0]    y;
	logic [PRICE_W-1:0]    prev;
	logic [57:0]           prod;
	logic [6:0]            shv;
	logic [57:0]           pres;
	logic [63:0]           dsum;
	logic [63:0]           dd;
	logic [63:0]           msq;
	logic [3:0]            eh;
	logic [63:0]           rtrial;
	logic [44:0]           se_full;
	logic [31:0]           se;

	assign pop       = (state_q == S_IDLE) && !empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	aomc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_comb begin
		div_start    = 1'b0;
		div_dividend = dev_q;
		div_divisor  = pp_q;
		unique case (state_q)
			S_AVG: begin
				div_start    = 1'b1;
				div_dividend = 64'(psum_q) + 64'(cfg.days >> 1);
				div_divisor  = 42'(cfg.days);
			end
			S_MEAN: begin
				div_start    = 1'b1;
				div_dividend = psum_acc_q + 64'(cfg.paths >> 1);
				div_divisor  = 42'(cfg.paths);
			end
			S_VAR: begin
				div_start = 1'b1;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_comb begin
		yneg    = ymul_q[55];
		ymag    = yneg ? 56'(-ymul_q) : 56'(ymul_q);
		yr      = 32'((ymag + 56'd8388608) >> 24);
		y       = yneg ? -$signed(yr) : $signed(yr);
		prev    = (day_q == '0) ? cfg.start_price : price_q;
		prod    = 58'(plo_q) + (58'(phi_q) << 16);
		shv     = 7'd24 - 7'(n_q);
		pres    = (prod + (58'd1 << (shv - 7'd1))) >> shv;
		dsum    = 64'(dlo_q) + (64'(dhi_q) << 22);
		dd      = (64'(hh_q) << 40) + (64'(hl_q) << 21) + 64'(ll_q);
		msq     = 64'(mslo_q) + (64'(mshi_q) << 20);
		rtrial  = rr_q + bit_q;
		se_full = 45'(rr_q[31:0]) << (4'd12 - eh_q);
		se      = (|se_full[44:32]) ? 32'hFFFF_FFFF : se_full[31:0];
		eh      = 4'd0;
		for (int i = 1; i <= 12; i++) begin
			if ((v_q >> (64 - 2 * i)) == 64'd0) begin
				eh = 4'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			day_q       <= '0;
			path_q      <= '0;
			psum_q      <= '0;
			psum_acc_q  <= '0;
			sq_acc_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!empty) begin
						state_q <= S_YMUL;
					end
				end
				S_YMUL:  state_q <= S_FRAC;
				S_FRAC:  state_q <= S_TMUL;
				S_TMUL:  state_q <= S_HMUL;
				S_HMUL:  state_q <= S_HDIV;
				S_HDIV: begin
					state_q <= (k_q == 3'd1) ? S_PMUL : S_HMUL;
				end
				S_PMUL:  state_q <= S_PRND;
				S_PRND:  state_q <= S_PACC;
				S_PACC: begin
					psum_q <= psum_q + PSUM_W'(price_q);
					if (({1'b0, day_q} + 12'd1) < {1'b0, cfg.days}) begin
						day_q   <= day_q + 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_AVG;
					end
				end
				S_AVG: begin
					psum_q  <= '0;
					day_q   <= '0;
					state_q <= S_AVGW;
				end
				S_AVGW: begin
					if (div_done) begin
						state_q <= S_PAY;
					end
				end
				S_PAY:   state_q <= S_DMUL;
				S_DMUL:  state_q <= S_DRND;
				S_DRND:  state_q <= S_SQMUL;
				S_SQMUL: state_q <= S_SQACC;
				S_SQACC: begin
					psum_acc_q <= psum_acc_q + 64'(d_q);
					sq_acc_q   <= sq_acc_q + (dd >> 24);
					if (({1'b0, path_q} + 22'd1) < {1'b0, cfg.paths}) begin
						path_q  <= path_q + 1'b1;
						state_q <= S_IDLE;
					end else begin
						path_q  <= '0;
						state_q <= S_MEAN;
					end
				end
				S_MEAN:  state_q <= S_MEANW;
				S_MEANW: begin
					if (div_done) begin
						state_q <= S_MMUL;
					end
				end
				S_MMUL:  state_q <= S_MSQ;
				S_MSQ:   state_q <= S_MSMUL;
				S_MSMUL: state_q <= S_DEV;
				S_DEV:   state_q <= S_VAR;
				S_VAR:   state_q <= S_VARW;
				S_VARW: begin
					if (div_done) begin
						state_q <= S_EXP;
					end
				end
				S_EXP:   state_q <= S_ROOT;
				S_ROOT: begin
					if (it_q == 5'd31) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						psum_acc_q  <= '0;
						sq_acc_q    <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				x_q <= pop_data;
			end
			S_YMUL: begin
				ymul_q <= $signed(56'(x_q)) * $signed(56'(LOG2E_Q24));
			end
			S_FRAC: begin
				n_q <= y[30:24];
				f_q <= y[23:0];
			end
			S_TMUL: begin
				t_q <= 24'(({24'b0, f_q} * {24'b0, LN2_Q24}) >> 24);
				p_q <= P_W'(ONE_Q24);
				k_q <= 3'd7;
			end
			S_HMUL: begin
				hm_q <= P_W'(({24'b0, p_q} * {26'b0, t_q}) >> 24);
			end
			S_HDIV: begin
				p_q <= P_W'(ONE_Q24) + P_W'(({30'b0, hm_q} * {26'b0, recip_q29(k_q)}) >> 29);
				k_q <= k_q - 3'd1;
			end
			S_PMUL: begin
				plo_q <= {26'b0, prev[15:0]} * {16'b0, p_q};
				phi_q <= {26'b0, prev[31:16]} * {16'b0, p_q};
			end
			S_PRND: begin
				price_q <= (|pres[57:32]) ? 32'hFFFF_FFFF : pres[31:0];
			end
			S_AVGW: begin
				avg_q <= div_quotient[42:0];
			end
			S_PAY: begin
				payoff_q <= (avg_q > {11'b0, cfg.strike_level}) ?
					avg_q - {11'b0, cfg.strike_level} : 43'd0;
			end
			S_DMUL: begin
				dlo_q <= {25'b0, payoff_q[21:0]} * {22'b0, cfg.discount};
				dhi_q <= {25'b0, payoff_q[42:22]} * {21'b0, cfg.discount};
			end
			S_DRND: begin
				d_q <= 40'((dsum + 64'd8388608) >> 24);
			end
			S_SQMUL: begin
				hh_q <= {20'b0, d_q[39:20]} * {20'b0, d_q[39:20]};
				hl_q <= {20'b0, d_q[39:20]} * {20'b0, d_q[19:0]};
				ll_q <= {20'b0, d_q[19:0]} * {20'b0, d_q[19:0]};
			end
			S_MEAN: begin
				pp_q <= {21'b0, cfg.paths} * {21'b0, cfg.paths - 21'd1};
			end
			S_MEANW: begin
				m_q <= div_quotient;
			end
			S_MMUL: begin
				mb_q  <= {32'b0, m_q[31:0]} * {32'b0, m_q[31:0]};
				mab_q <= 32'({32'b0, m_q[63:32]} * {32'b0, m_q[31:0]});
			end
			S_MSQ: begin
				mm_q <= 40'((mb_q + {mab_q[30:0], 33'b0}) >> 24);
			end
			S_MSMUL: begin
				mslo_q <= {21'b0, mm_q[19:0]} * {20'b0, cfg.paths};
				mshi_q <= {21'b0, mm_q[39:20]} * {20'b0, cfg.paths};
			end
			S_DEV: begin
				dev_q <= (sq_acc_q > msq) ? sq_acc_q - msq : 64'd0;
			end
			S_VARW: begin
				v_q <= div_quotient;
			end
			S_EXP: begin
				eh_q  <= eh;
				rv_q  <= v_q << {eh, 1'b0};
				rr_q  <= '0;
				bit_q <= 64'd1 << 62;
				it_q  <= '0;
			end
			S_ROOT: begin
				if (rv_q >= rtrial) begin
					rv_q <= rv_q - rtrial;
					rr_q <= (rr_q >> 1) + bit_q;
				end else begin
					rr_q <= rr_q >> 1;
				end
				bit_q <= bit_q >> 2;
				it_q  <= it_q + 1'b1;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_data_q <= {se, m_q[31:0]};
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/asian_option_monte_carlo_top.sv
// Top level of the arithmetic-average Asian call Monte Carlo pricer.
// A sample is registered in the front end, queued, then popped in S_IDLE and summed in S_PACC.
// The back end takes one item at a time; the exp sequencer runs seven Horner steps per item.
// Path ends and run ends add divides on the shared divider; a run end also adds a square root.
// The front end and a 4-entry queue keep taking items while the back end works.
// Reset (arst_n low, asynchronous): registers return to defaults, counters and sums clear.
`default_nettype none
module asian_option_monte_carlo_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] normal_sample
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [31:0] price_estimate, [63:32] standard_error
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import aomc_pkg::*;

	logic [31:0]        start_price_q;
	logic [31:0]        strike_level_q;
	logic [23:0]        drift_q;
	logic [23:0]        diffusion_q;
	logic [24:0]        discount_q;
	logic [DAYS_W-1:0]  days_q;
	logic [PATHS_W-1:0] paths_q;
	cfg_t               cfg;

	logic                  push;
	logic signed [X_W-1:0] push_x;
	logic                  full;
	logic                  pop;
	logic signed [X_W-1:0] pop_data;
	logic                  empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_price_q  <= 32'd6488064;
			strike_level_q <= 32'd6881280;
			drift_q        <= 24'hFFD8FD;
			diffusion_q    <= 24'd634118;
			discount_q     <= 25'd16598420;
			days_q         <= 11'd90;
			paths_q        <= 21'd100000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_PRICE: start_price_q  <= cfg_data;
				REG_STRIKE:      strike_level_q <= cfg_data;
				REG_DRIFT:       drift_q        <= cfg_data[23:0];
				REG_DIFFUSION:   diffusion_q    <= cfg_data[23:0];
				REG_DISCOUNT:    discount_q     <= cfg_data[24:0];
				REG_DAYS:        days_q         <= cfg_data[DAYS_W-1:0];
				REG_PATHS:       paths_q        <= cfg_data[PATHS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.start_price  = start_price_q;
		cfg.strike_level = strike_level_q;
		cfg.drift        = $signed(drift_q);
		cfg.diffusion    = diffusion_q;
		cfg.discount     = (discount_q > ONE_Q24) ? ONE_Q24 : discount_q;
		cfg.days         = (days_q == '0) ? DAYS_W'(1) :
			(days_q > MAX_DAYS) ? MAX_DAYS : days_q;
		cfg.paths        = (paths_q < PATHS_W'(2)) ? PATHS_W'(2) :
			(paths_q > MAX_PATHS) ? MAX_PATHS : paths_q;
	end

	aomc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_sample ($signed(s_axis_tdata)),
		.push      (push),
		.push_x    (push_x),
		.full      (full)
	);

	aomc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_x),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	aomc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
`default_nettype wire

>>> rtl/aomc_checker.sv
// Port-level checks of the pricer top level, bound to it.
`default_nettype none
module aomc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata
);

	a_reset_no_result: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("result valid right after reset");

	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))
		else $error("input ready dropped without an accepted item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

endmodule

bind asian_option_monte_carlo_top aomc_checker u_aomc_checker (.*);
`default_nettype wire
